@@ sv/mtsvg_pkg.sv @@
// ----------------------------------------------------------------------------
// mtsvg_pkg
// Shared types and constants of the multi-target state vector gate unit.
// ----------------------------------------------------------------------------
package mtsvg_pkg;

    localparam int DATA_W         = 32;
    localparam int MAX_QUBITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 30;
    localparam int MAX_TARGETS    = 3;
    localparam int IDX_W          = 10;
    localparam int MAT_AW         = 6;
    localparam int MAT_DEPTH      = 64;
    localparam int DIM_W          = 3;
    localparam int QC_W           = 4;
    localparam int TC_W           = 2;
    localparam int TGT_W          = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_QUBITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TCOUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT2   = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD_AMP = 2'd0,
        OP_LOAD_MAT = 2'd1,
        OP_APPLY    = 2'd2,
        OP_READ_AMP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_TARGET = 2'd2
    } status_t;

    // product selection: matrix part times buffer part
    typedef enum logic [1:0] {
        MS_RR = 2'd0,
        MS_II = 2'd1,
        MS_RI = 2'd2,
        MS_IR = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic                 amp_rd;
        logic                 amp_wr_load;
        logic                 amp_wr_acc;
        logic                 gather;
        logic [DIM_W-1:0]     buf_idx;
        logic                 mat_rd;
        logic                 mat_wr;
        logic                 mul_en;
        mul_sel_t             mul_sel;
        logic [DIM_W-1:0]     col;
        logic                 acc_clr;
        logic                 res_valid;
        logic                 res_read;
        status_t              res_status;
    } dp_cmd_t;

endpackage

@@ sv/mtsvg_dp.sv @@
// ----------------------------------------------------------------------------
// mtsvg_dp
// Datapath: amplitude and matrix memories, gather buffer, multiplier,
// accumulators with saturation, and result registers.
// ----------------------------------------------------------------------------
module mtsvg_dp #(
    parameter int MAX_QUBITS = mtsvg_pkg::MAX_QUBITS_DEF,
    parameter int FRAC_BITS  = mtsvg_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mtsvg_pkg::dp_cmd_t                    cmd,
    input  logic [MAX_QUBITS-1:0]                 amp_addr,
    input  logic [mtsvg_pkg::MAT_AW-1:0]          mat_addr,
    input  logic signed [mtsvg_pkg::DATA_W-1:0]   value_real,
    input  logic signed [mtsvg_pkg::DATA_W-1:0]   value_imag,
    output logic                                  done,
    output logic signed [mtsvg_pkg::DATA_W-1:0]   read_real,
    output logic signed [mtsvg_pkg::DATA_W-1:0]   read_imag,
    output logic [1:0]                            status
);
    import mtsvg_pkg::*;

    localparam int AMP_DEPTH = 1 << MAX_QUBITS;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W - FRAC_BITS + 5;
    localparam int NBUF      = 1 << DIM_W;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic [2*DATA_W-1:0] amp_mem [AMP_DEPTH];
    logic [2*DATA_W-1:0] mat_mem [MAT_DEPTH];
    logic [2*DATA_W-1:0] amp_q_reg;
    logic [2*DATA_W-1:0] mat_q_reg;
    logic [2*DATA_W-1:0] amp_wdata;

    logic signed [DATA_W-1:0] buf_re_reg [NBUF];
    logic signed [DATA_W-1:0] buf_im_reg [NBUF];
    logic                     g_vld_reg;
    logic [DIM_W-1:0]         g_idx_reg;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg;
    mul_sel_t                 psel_reg;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  accr_reg;
    logic signed [ACC_W-1:0]  acci_reg;
    logic signed [DATA_W-1:0] satr;
    logic signed [DATA_W-1:0] sati;

    logic                     done_reg;
    logic                     rdsel_reg;
    logic [1:0]               status_reg;

    always_comb
    begin
        if (accr_reg > SAT_HI)
            satr = DATA_W'(SAT_HI);
        else if (accr_reg < SAT_LO)
            satr = DATA_W'(SAT_LO);
        else
            satr = DATA_W'(accr_reg);
        if (acci_reg > SAT_HI)
            sati = DATA_W'(SAT_HI);
        else if (acci_reg < SAT_LO)
            sati = DATA_W'(SAT_LO);
        else
            sati = DATA_W'(acci_reg);
    end

    assign amp_wdata = cmd.amp_wr_load ? {value_real, value_imag} : {satr, sati};

    always_ff @(posedge clk)
    begin
        if (cmd.amp_wr_load || cmd.amp_wr_acc)
            amp_mem[amp_addr] <= amp_wdata;
        if (cmd.amp_rd)
            amp_q_reg <= amp_mem[amp_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mat_wr)
            mat_mem[mat_addr] <= {value_real, value_imag};
        if (cmd.mat_rd)
            mat_q_reg <= mat_mem[mat_addr];
    end

    always_ff @(posedge clk)
    begin
        if (g_vld_reg)
        begin
            buf_re_reg[g_idx_reg] <= amp_q_reg[2*DATA_W-1:DATA_W];
            buf_im_reg[g_idx_reg] <= amp_q_reg[DATA_W-1:0];
        end
    end

    always_comb
    begin
        if (cmd.mul_sel == MS_RR || cmd.mul_sel == MS_RI)
            mul_a = mat_q_reg[2*DATA_W-1:DATA_W];
        else
            mul_a = mat_q_reg[DATA_W-1:0];
        if (cmd.mul_sel == MS_RR || cmd.mul_sel == MS_IR)
            mul_b = buf_re_reg[cmd.col];
        else
            mul_b = buf_im_reg[cmd.col];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        psel_reg <= cmd.mul_sel;
    end

    // floor of the product by the arithmetic shift
    assign term = ACC_W'(prod_reg >>> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg  <= 1'b0;
            g_idx_reg  <= '0;
            pv_reg     <= 1'b0;
            accr_reg   <= '0;
            acci_reg   <= '0;
            done_reg   <= 1'b0;
            rdsel_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            g_vld_reg  <= cmd.amp_rd && cmd.gather;
            g_idx_reg  <= cmd.buf_idx;
            pv_reg     <= cmd.mul_en;
            done_reg   <= cmd.res_valid;
            rdsel_reg  <= cmd.res_valid && cmd.res_read;
            status_reg <= cmd.res_status;
            if (cmd.acc_clr)
            begin
                accr_reg <= '0;
                acci_reg <= '0;
            end
            else if (pv_reg)
            begin
                case (psel_reg)
                    MS_RR:   accr_reg <= accr_reg + term;
                    MS_II:   accr_reg <= accr_reg - term;
                    default: acci_reg <= acci_reg + term;
                endcase
            end
        end
    end

    assign done      = done_reg;
    assign status    = done_reg ? status_reg : ST_OK;
    assign read_real = rdsel_reg ? amp_q_reg[2*DATA_W-1:DATA_W] : '0;
    assign read_imag = rdsel_reg ? amp_q_reg[DATA_W-1:0] : '0;

endmodule

@@ sv/mtsvg_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtsvg_ctrl
// Controller: configuration registers, item decode, target checks and the
// sequencer that walks base indices, gathers, multiplies and writes back.
// ----------------------------------------------------------------------------
module mtsvg_ctrl #(
    parameter int MAX_QUBITS = mtsvg_pkg::MAX_QUBITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            op,
    input  logic [mtsvg_pkg::IDX_W-1:0]           index,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mtsvg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mtsvg_pkg::CFG_DATA_W-1:0]      cfg_data,
    output mtsvg_pkg::dp_cmd_t                    cmd,
    output logic [MAX_QUBITS-1:0]                 amp_addr,
    output logic [mtsvg_pkg::MAT_AW-1:0]          mat_addr
);
    import mtsvg_pkg::*;

    localparam int AW = MAX_QUBITS;
    localparam int NW = $clog2(MAX_QUBITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GATHER,
        S_GWAIT,
        S_MREAD,
        S_MUL,
        S_DRAIN,
        S_WB
    } state_t;

    state_t            state_reg, state_next;
    logic [QC_W-1:0]   qc_reg;
    logic [TC_W-1:0]   tc_reg;
    logic [TGT_W-1:0]  t0_reg, t1_reg, t2_reg;
    logic [TGT_W-1:0]  srt_reg [MAX_TARGETS];
    logic [TGT_W-1:0]  srt_next [MAX_TARGETS];
    logic [AW-1:0]     s_reg, s_next;
    logic [AW-1:0]     smax_reg, smax_next;
    logic [DIM_W-1:0]  dmax_reg, dmax_next;
    logic [DIM_W-1:0]  y_reg, y_next;
    logic [DIM_W-1:0]  j_reg, j_next;
    logic [1:0]        p_reg, p_next;

    logic [NW-1:0]     n_eff;
    logic              amp_oob;
    logic              mat_oob;
    logic              tgt_bad;
    logic              use1, use2;
    logic [TGT_W-1:0]  lo01, hi01, mid_a, mid_b;
    logic [AW-1:0]     base;
    logic [AW-1:0]     low;
    logic [AW-1:0]     mask_y;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;

    assign n_eff   = (int'(qc_reg) > MAX_QUBITS) ? NW'(MAX_QUBITS) : NW'(qc_reg);
    assign amp_oob = (index >> n_eff) != '0;
    assign mat_oob = index[IDX_W-1:MAT_AW] != '0;
    assign use1    = tc_reg >= 2'd2;
    assign use2    = tc_reg == 2'd3;

    always_comb
    begin
        tgt_bad = (tc_reg == '0) || (int'(tc_reg) > MAX_TARGETS) ||
                  (int'(tc_reg) > int'(n_eff)) || (int'(t0_reg) >= int'(n_eff));
        if (use1 && ((int'(t1_reg) >= int'(n_eff)) || (t1_reg == t0_reg)))
            tgt_bad = 1'b1;
        if (use2 && ((int'(t2_reg) >= int'(n_eff)) || (t2_reg == t0_reg) ||
                     (t2_reg == t1_reg)))
            tgt_bad = 1'b1;
    end

    always_comb
    begin
        lo01  = (t0_reg < t1_reg) ? t0_reg : t1_reg;
        hi01  = (t0_reg < t1_reg) ? t1_reg : t0_reg;
        mid_a = (lo01 < t2_reg) ? t2_reg : lo01;
        mid_b = (hi01 < mid_a) ? hi01 : mid_a;
        for (int i = 0; i < MAX_TARGETS; i++)
            srt_next[i] = srt_reg[i];
        if (accept && op == OP_APPLY)
        begin
            if (use2)
            begin
                srt_next[0] = (lo01 < t2_reg) ? lo01 : t2_reg;
                srt_next[1] = mid_b;
                srt_next[2] = (hi01 < mid_a) ? mid_a : hi01;
            end
            else
            begin
                srt_next[0] = use1 ? lo01 : t0_reg;
                srt_next[1] = hi01;
                srt_next[2] = t2_reg;
            end
        end
    end

    always_comb
    begin
        base = s_reg;
        for (int j = 0; j < MAX_TARGETS; j++)
        begin
            low = (AW'(1) << srt_reg[j]) - AW'(1);
            if (j < int'(tc_reg))
                base = (base & low) | ((base & ~low) << 1);
        end
        mask_y = '0;
        if (y_reg[0])
            mask_y = mask_y | (AW'(1) << t0_reg);
        if (y_reg[1])
            mask_y = mask_y | (AW'(1) << t1_reg);
        if (y_reg[2])
            mask_y = mask_y | (AW'(1) << t2_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        s_next     = s_reg;
        smax_next  = smax_reg;
        dmax_next  = dmax_reg;
        y_next     = y_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        cmd        = '0;
        cmd.res_status = ST_OK;
        cmd.mul_sel    = mul_sel_t'(p_reg);
        cmd.col        = j_reg;
        cmd.buf_idx    = y_reg;
        amp_addr   = base ^ mask_y;
        mat_addr   = {y_reg, j_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                amp_addr = AW'(index);
                mat_addr = index[MAT_AW-1:0];
                if (accept)
                begin
                    unique case (op_t'(op))
                        OP_LOAD_AMP:
                        begin
                            cmd.res_valid   = 1'b1;
                            cmd.res_status  = amp_oob ? ST_RANGE : ST_OK;
                            cmd.amp_wr_load = !amp_oob;
                        end
                        OP_LOAD_MAT:
                        begin
                            cmd.res_valid  = 1'b1;
                            cmd.res_status = mat_oob ? ST_RANGE : ST_OK;
                            cmd.mat_wr     = !mat_oob;
                        end
                        OP_READ_AMP:
                        begin
                            cmd.res_valid  = 1'b1;
                            cmd.res_status = amp_oob ? ST_RANGE : ST_OK;
                            cmd.amp_rd     = !amp_oob;
                            cmd.res_read   = !amp_oob;
                        end
                        OP_APPLY:
                        begin
                            if (tgt_bad)
                            begin
                                cmd.res_valid  = 1'b1;
                                cmd.res_status = ST_TARGET;
                            end
                            else
                            begin
                                cmd.acc_clr = 1'b1;
                                s_next      = '0;
                                y_next      = '0;
                                smax_next   = AW'((32'd1 << (n_eff - NW'(tc_reg))) - 32'd1);
                                dmax_next   = DIM_W'((4'd1 << tc_reg) - 4'd1);
                                state_next  = S_GATHER;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_GATHER:
            begin
                cmd.amp_rd = 1'b1;
                cmd.gather = 1'b1;
                if (y_reg == dmax_reg)
                    state_next = S_GWAIT;
                else
                    y_next = y_reg + 1'b1;
            end
            S_GWAIT:
            begin
                y_next     = '0;
                j_next     = '0;
                state_next = S_MREAD;
            end
            S_MREAD:
            begin
                cmd.mat_rd = 1'b1;
                p_next     = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                p_next     = p_reg + 1'b1;
                if (p_reg == 2'd3)
                begin
                    if (j_reg == dmax_reg)
                        state_next = S_DRAIN;
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_MREAD;
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.amp_wr_acc = 1'b1;
                cmd.acc_clr    = 1'b1;
                j_next         = '0;
                if (y_reg == dmax_reg)
                begin
                    y_next = '0;
                    if (s_reg == smax_reg)
                    begin
                        cmd.res_valid = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        s_next     = s_reg + 1'b1;
                        state_next = S_GATHER;
                    end
                end
                else
                begin
                    y_next     = y_reg + 1'b1;
                    state_next = S_MREAD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            qc_reg    <= QC_W'(10);
            tc_reg    <= TC_W'(1);
            t0_reg    <= TGT_W'(0);
            t1_reg    <= TGT_W'(1);
            t2_reg    <= TGT_W'(2);
            s_reg     <= '0;
            smax_reg  <= '0;
            dmax_reg  <= '0;
            y_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
            for (int i = 0; i < MAX_TARGETS; i++)
                srt_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            s_reg     <= s_next;
            smax_reg  <= smax_next;
            dmax_reg  <= dmax_next;
            y_reg     <= y_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
            for (int i = 0; i < MAX_TARGETS; i++)
                srt_reg[i] <= srt_next[i];
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_QUBITS: qc_reg <= cfg_data[QC_W-1:0];
                    CFG_TCOUNT: tc_reg <= cfg_data[TC_W-1:0];
                    CFG_TGT0:   t0_reg <= cfg_data[TGT_W-1:0];
                    CFG_TGT1:   t1_reg <= cfg_data[TGT_W-1:0];
                    CFG_TGT2:   t2_reg <= cfg_data[TGT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ sv/multi_target_state_vector_gate_unit.sv @@
// ----------------------------------------------------------------------------
// multi_target_state_vector_gate_unit
// Load, load-matrix and read items: one per cycle, result in the next cycle.
// Apply: 2^(n-k) base indices, each with a gather of 2^k amplitudes and a
// wait state, then per row a matrix read and multiply per column, a drain and
// a writeback; the single shared multiplier serves all products. Result strobe
// comes with busy falling. Reset: asynchronous active-low; control registers
// return to defaults, memories keep contents. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module multi_target_state_vector_gate_unit #(
    parameter int MAX_QUBITS = mtsvg_pkg::MAX_QUBITS_DEF,
    parameter int FRAC_BITS  = mtsvg_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            op,
    input  logic [mtsvg_pkg::IDX_W-1:0]           index,
    input  logic signed [mtsvg_pkg::DATA_W-1:0]   value_real,
    input  logic signed [mtsvg_pkg::DATA_W-1:0]   value_imag,
    output logic                                  done,
    output logic signed [mtsvg_pkg::DATA_W-1:0]   read_real,
    output logic signed [mtsvg_pkg::DATA_W-1:0]   read_imag,
    output logic [1:0]                            status,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mtsvg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mtsvg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mtsvg_pkg::*;

    dp_cmd_t                 cmd;
    logic [MAX_QUBITS-1:0]   amp_addr;
    logic [MAT_AW-1:0]       mat_addr;

    mtsvg_ctrl #(
        .MAX_QUBITS (MAX_QUBITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .index     (index),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .amp_addr  (amp_addr),
        .mat_addr  (mat_addr)
    );

    mtsvg_dp #(
        .MAX_QUBITS (MAX_QUBITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .amp_addr   (amp_addr),
        .mat_addr   (mat_addr),
        .value_real (value_real),
        .value_imag (value_imag),
        .done       (done),
        .read_real  (read_real),
        .read_imag  (read_imag),
        .status     (status)
    );

endmodule

@@ sv/mtsvg_checker.sv @@
// ----------------------------------------------------------------------------
// mtsvg_checker
// Port-level checks of the gate unit, bound to the top level.
// ----------------------------------------------------------------------------
module mtsvg_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic [1:0]                            op,
    input logic                                  done,
    input logic signed [mtsvg_pkg::DATA_W-1:0]   read_real,
    input logic signed [mtsvg_pkg::DATA_W-1:0]   read_imag,
    input logic [1:0]                            status
);
    import mtsvg_pkg::*;

    // loads and reads answer in the next cycle
    a_fast_reply: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op != OP_APPLY |=> done && !busy)
        else $error("load/read transfer not answered next cycle");

    a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result while apply in progress");

    a_apply_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done && status == ST_OK)
        else $error("apply finished without ok result");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> read_real == 0 && read_imag == 0)
        else $error("error result carries read data");

endmodule

bind multi_target_state_vector_gate_unit mtsvg_checker u_mtsvg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .done      (done),
    .read_real (read_real),
    .read_imag (read_imag),
    .status    (status)
);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for multi_target_state_vector_gate_unit
// Drives load, read and apply items through the start/busy port and moves
// the target registers between runs. A local state-vector model predicts
// every result. Each done strobe is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import mtsvg_pkg::*;

    localparam int FRAC   = FRAC_BITS_DEF;
    localparam int NQ_MAX = MAX_QUBITS_DEF;
    localparam int AMP_N  = 1 << NQ_MAX;

    typedef struct {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [1:0]               st;
    } gate_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    op_t                        op;
    logic [IDX_W-1:0]           index;
    logic signed [DATA_W-1:0]   value_real;
    logic signed [DATA_W-1:0]   value_imag;
    logic                       done;
    logic signed [DATA_W-1:0]   read_real;
    logic signed [DATA_W-1:0]   read_imag;
    logic [1:0]                 status;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // local copy of the block state
    int           amp_re [AMP_N];
    int           amp_im [AMP_N];
    int           mat_re [MAT_DEPTH];
    int           mat_im [MAT_DEPTH];
    bit           amp_written [AMP_N];
    int unsigned  qubits_reg;
    int unsigned  tcount_reg;
    int unsigned  tgt_reg [3];

    gate_result_t pending_results [$];
    int           mismatch_count;
    int           items_sent;
    int           applies_done;
    int           error_statuses;
    bit           no_gaps;

    multi_target_state_vector_gate_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .index      (index),
        .value_real (value_real),
        .value_imag (value_imag),
        .done       (done),
        .read_real  (read_real),
        .read_imag  (read_imag),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint fix_mul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC;
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return int'(v);
    endfunction

    function automatic int unsigned eff_qubits();
        return (qubits_reg > NQ_MAX) ? NQ_MAX : qubits_reg;
    endfunction

    function automatic status_t gate_apply();
        int unsigned n;
        int unsigned k;
        int unsigned srt [3];
        int unsigned mask [8];
        int          br [8];
        int          bi [8];
        int unsigned dim;
        int unsigned base;
        int unsigned low;
        int unsigned tmp;
        int unsigned a;
        longint      accr;
        longint      acci;
        n = eff_qubits();
        k = tcount_reg;
        if (k == 0 || k > MAX_TARGETS || k > n)
            return ST_TARGET;
        for (int i = 0; i < k; i++)
        begin
            if (tgt_reg[i] >= n)
                return ST_TARGET;
            for (int j = 0; j < i; j++)
                if (tgt_reg[i] == tgt_reg[j])
                    return ST_TARGET;
        end
        for (int i = 0; i < k; i++)
            srt[i] = tgt_reg[i];
        for (int i = 1; i < k; i++)
            for (int j = i; j > 0 && srt[j-1] > srt[j]; j--)
            begin
                tmp = srt[j];
                srt[j] = srt[j-1];
                srt[j-1] = tmp;
            end
        dim = 1 << k;
        for (int i = 0; i < dim; i++)
        begin
            mask[i] = 0;
            for (int j = 0; j < k; j++)
                if ((i >> j) & 1)
                    mask[i] |= 1 << tgt_reg[j];
        end
        for (int unsigned s = 0; s < (1 << (n - k)); s++)
        begin
            base = s;
            for (int j = 0; j < k; j++)
            begin
                low = (1 << srt[j]) - 1;
                base = (base & low) | ((base & ~low) << 1);
            end
            for (int i = 0; i < dim; i++)
            begin
                a = (base ^ mask[i]) & (AMP_N - 1);
                br[i] = amp_re[a];
                bi[i] = amp_im[a];
            end
            for (int i = 0; i < dim; i++)
            begin
                accr = 0;
                acci = 0;
                for (int j = 0; j < dim; j++)
                begin
                    accr += fix_mul(mat_re[i*8+j], br[j]) - fix_mul(mat_im[i*8+j], bi[j]);
                    acci += fix_mul(mat_re[i*8+j], bi[j]) + fix_mul(mat_im[i*8+j], br[j]);
                end
                a = (base ^ mask[i]) & (AMP_N - 1);
                amp_re[a] = sat32(accr);
                amp_im[a] = sat32(acci);
            end
        end
        return ST_OK;
    endfunction

    function automatic gate_result_t predict_item(op_t o, int unsigned idx, int vr, int vi);
        gate_result_t r;
        int unsigned  len;
        len = 1 << eff_qubits();
        r.re = 0;
        r.im = 0;
        r.st = ST_OK;
        case (o)
            OP_LOAD_AMP:
                if (idx >= len)
                    r.st = ST_RANGE;
                else
                begin
                    amp_re[idx] = vr;
                    amp_im[idx] = vi;
                    amp_written[idx] = 1'b1;
                end
            OP_LOAD_MAT:
                if (idx >= MAT_DEPTH)
                    r.st = ST_RANGE;
                else
                begin
                    mat_re[idx] = vr;
                    mat_im[idx] = vi;
                end
            OP_APPLY:
                r.st = gate_apply();
            default:
                if (idx >= len)
                    r.st = ST_RANGE;
                else
                begin
                    r.re = amp_re[idx];
                    r.im = amp_im[idx];
                end
        endcase
        if (r.st != ST_OK)
            error_statuses++;
        else if (o == OP_APPLY)
            applies_done++;
        return r;
    endfunction

    always @(posedge clk)
    begin
        gate_result_t e;
        if (done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing pending", $realtime);
            end
            else
            begin
                e = pending_results.pop_front();
                if (read_real !== e.re || read_imag !== e.im || status !== e.st)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                                 $realtime, e.re, e.im, e.st, read_real, read_imag, status);
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic int rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return int'($urandom_range(0, 32'h7fffffff)) - 32'h40000000;
            2: return int'($urandom_range(0, 32'h7ffffff)) - 32'h4000000;
            default:
                case ($urandom_range(0, 3))
                    0: return 32'h80000000;
                    1: return 32'h7fffffff;
                    2: return 0;
                    default: return -1;
                endcase
        endcase
    endfunction

    task automatic send_item(op_t o, int unsigned idx, int vr, int vi);
        int unsigned gap;
        start      <= 1'b1;
        op         <= o;
        index      <= idx[IDX_W-1:0];
        value_real <= vr;
        value_imag <= vi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_item(o, idx, vr, vi));
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] d);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (ri)
            CFG_QUBITS: qubits_reg = 32'(d);
            CFG_TCOUNT: tcount_reg = 32'(d[TC_W-1:0]);
            CFG_TGT0:   tgt_reg[0] = 32'(d);
            CFG_TGT1:   tgt_reg[1] = 32'(d);
            CFG_TGT2:   tgt_reg[2] = 32'(d);
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned n, int unsigned k, int unsigned t0,
                              int unsigned t1, int unsigned t2);
        write_reg(CFG_QUBITS, CFG_DATA_W'(n));
        write_reg(CFG_TCOUNT, {2'($urandom_range(0, 3)), 2'(k)});
        write_reg(CFG_TGT0, CFG_DATA_W'(t0));
        write_reg(CFG_TGT1, CFG_DATA_W'(t1));
        write_reg(CFG_TGT2, CFG_DATA_W'(t2));
    endtask

    task automatic fill_amplitudes();
        for (int unsigned i = 0; i < (1 << eff_qubits()); i++)
            if (!amp_written[i])
                send_item(OP_LOAD_AMP, i, rand_value(), rand_value());
    endtask

    task automatic test_matrix_fill();
        for (int unsigned i = 0; i < MAT_DEPTH; i++)
            send_item(OP_LOAD_MAT, i, rand_value(), rand_value());
    endtask

    task automatic test_directed();
        set_config(2, 1, 0, 1, 2);
        send_item(OP_LOAD_AMP, 0, 32'h80000000, 32'h7fffffff);
        send_item(OP_LOAD_AMP, 1, 32'h7fffffff, 32'h80000000);
        send_item(OP_LOAD_AMP, 2, 0, -1);
        send_item(OP_LOAD_AMP, 3, 32'h40000000, 32'hc0000000);
        send_item(OP_LOAD_AMP, 4, 1, 1);
        send_item(OP_LOAD_AMP, 1023, 1, 1);
        send_item(OP_LOAD_MAT, 63, 32'h7fffffff, 32'h80000000);
        send_item(OP_LOAD_MAT, 64, 1, 1);
        send_item(OP_LOAD_MAT, 1023, 1, 1);
        send_item(OP_READ_AMP, 0, 0, 0);
        send_item(OP_READ_AMP, 3, 0, 0);
        send_item(OP_READ_AMP, 4, 0, 0);
        send_item(OP_READ_AMP, 1023, 0, 0);
        send_item(OP_APPLY, 0, 0, 0);
        for (int unsigned i = 0; i < 4; i++)
            send_item(OP_READ_AMP, i, 0, 0);
        set_config(2, 2, 1, 0, 2);
        send_item(OP_APPLY, 0, 0, 0);
        write_reg(CFG_TGT1, 1);
        send_item(OP_APPLY, 0, 0, 0);
        set_config(2, 3, 0, 1, 2);
        send_item(OP_APPLY, 0, 0, 0);
        set_config(2, 1, 2, 1, 0);
        send_item(OP_APPLY, 0, 0, 0);
        write_reg(CFG_TCOUNT, 0);
        send_item(OP_APPLY, 0, 0, 0);
        set_config(0, 1, 0, 1, 2);
        send_item(OP_LOAD_AMP, 0, rand_value(), rand_value());
        send_item(OP_LOAD_AMP, 1, 5, 5);
        send_item(OP_READ_AMP, 0, 0, 0);
        send_item(OP_APPLY, 0, 0, 0);
    endtask

    task automatic random_item(int unsigned apply_pct);
        int unsigned r;
        int unsigned len;
        int unsigned idx;
        len = 1 << eff_qubits();
        r = $urandom_range(0, 99);
        if (len < AMP_N && $urandom_range(0, 9) == 0)
            idx = $urandom_range(len, AMP_N - 1);
        else
            idx = $urandom_range(0, len - 1);
        if (r < apply_pct)
            send_item(OP_APPLY, $urandom_range(0, AMP_N - 1), rand_value(), rand_value());
        else if (r < 35)
            send_item(OP_LOAD_AMP, idx, rand_value(), rand_value());
        else if (r < 50)
            send_item(OP_LOAD_MAT,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(MAT_DEPTH, AMP_N - 1)
                                                  : $urandom_range(0, MAT_DEPTH - 1),
                      rand_value(), rand_value());
        else
            send_item(OP_READ_AMP, idx, rand_value(), rand_value());
    endtask

    task automatic test_random_phases();
        int unsigned n;
        int unsigned k;
        int unsigned t [3];
        for (int p = 0; p < 14; p++)
        begin
            n = $urandom_range(1, 6);
            k = $urandom_range(1, 3);
            if ($urandom_range(0, 4) != 0 && k <= n)
            begin
                t[0] = $urandom_range(0, n - 1);
                do t[1] = $urandom_range(0, n - 1); while (k >= 2 && t[1] == t[0]);
                do t[2] = $urandom_range(0, n - 1);
                while (k == 3 && (t[2] == t[0] || t[2] == t[1]));
            end
            else
                foreach (t[i]) t[i] = $urandom_range(0, 15);
            set_config(n, k, t[0], t[1], t[2]);
            fill_amplitudes();
            no_gaps = (p % 4 == 3);
            if (p == 5)
            begin
                for (int i = 0; i < 10; i++)
                    random_item(10);
                wait_drain();
            end
            for (int i = 0; i < 35; i++)
                random_item(10);
            no_gaps = 1'b0;
        end
    endtask

    task automatic test_full_state();
        set_config(9, 1, 8, 0, 0);
        fill_amplitudes();
        send_item(OP_APPLY, 0, 0, 0);
        for (int i = 0; i < 30; i++)
            random_item(0);
        send_item(OP_APPLY, 0, 0, 0);
        // count above the limit clamps, so qubit 12 is out of range
        set_config(15, 1, 12, 0, 0);
        send_item(OP_APPLY, 0, 0, 0);
        send_item(OP_LOAD_AMP, 1000, rand_value(), rand_value());
        send_item(OP_READ_AMP, 1000, 0, 0);
        for (int i = 0; i < 10; i++)
            send_item(OP_READ_AMP, $urandom_range(0, (AMP_N / 2) - 1), 0, 0);
        set_config(15, 3, 15, 0, 5);
        send_item(OP_APPLY, 0, 0, 0);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        op             = OP_LOAD_AMP;
        index          = '0;
        value_real     = '0;
        value_imag     = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        qubits_reg     = 10;
        tcount_reg     = 1;
        tgt_reg        = '{0, 1, 2};
        mismatch_count = 0;
        items_sent     = 0;
        applies_done   = 0;
        error_statuses = 0;
        no_gaps        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_matrix_fill();
        test_directed();
        test_random_phases();
        test_full_state();
        wait_drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d transfers: %0d gate applications, %0d range/target errors.",
                 items_sent, applies_done, error_statuses);
        $display("Qubit counts 0..15, one to three targets, mismatches: %0d.", mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
